FILE: sv/sts_pkg.sv
// Package: shared types, token codes and keyword lookup for the SQL token scanner.
`timescale 1ns / 1ps
package sts_pkg;

  localparam int KwMaxLen = 7;
  localparam int PosBits = 32;
  localparam int KwIdxBits = $clog2(KwMaxLen);

  typedef enum logic [3:0] {
    M_IDLE, M_WORD, M_DIGITS, M_DASH, M_SLASH, M_LT, M_GT, M_BANG,
    M_QUOTED, M_QUOTE_SEEN, M_LINE_REM, M_BLOCK_REM, M_BLOCK_STAR
  } mode_t;

  localparam logic [5:0] T_EOF = 6'd0;
  localparam logic [5:0] T_IDENT = 6'd1;
  localparam logic [5:0] T_INTEGER = 6'd2;
  localparam logic [5:0] T_STRING = 6'd3;
  localparam logic [5:0] T_INVALID = 6'd4;
  localparam logic [5:0] T_LPAREN = 6'd32;
  localparam logic [5:0] T_RPAREN = 6'd33;
  localparam logic [5:0] T_COMMA = 6'd34;
  localparam logic [5:0] T_SEMI = 6'd35;
  localparam logic [5:0] T_DOT = 6'd36;
  localparam logic [5:0] T_PLUS = 6'd37;
  localparam logic [5:0] T_MINUS = 6'd38;
  localparam logic [5:0] T_STAR = 6'd39;
  localparam logic [5:0] T_SLASH = 6'd40;
  localparam logic [5:0] T_PERCENT = 6'd41;
  localparam logic [5:0] T_EQ = 6'd42;
  localparam logic [5:0] T_NE = 6'd43;
  localparam logic [5:0] T_LT = 6'd44;
  localparam logic [5:0] T_LE = 6'd45;
  localparam logic [5:0] T_GT = 6'd46;
  localparam logic [5:0] T_GE = 6'd47;

  localparam logic [1:0] E_NONE = 2'd0;
  localparam logic [1:0] E_CHAR = 2'd1;
  localparam logic [1:0] E_BANG = 2'd2;
  localparam logic [1:0] E_UNTERM = 2'd3;

  localparam logic [23:0] LineSat = 24'hFFFFFF;
  localparam logic [15:0] ColSat = 16'hFFFF;

  typedef logic [KwMaxLen-1:0][7:0] kwbuf_t;

  typedef struct packed {
    logic [5:0]  token_type;
    logic [1:0]  error_code;
    logic [31:0] start_offset;
    logic [31:0] span_length;
    logic [23:0] first_line;
    logic [15:0] start_column;
  } token_t;

  // Keyword lookup on an upper-cased word of len bytes.
  function automatic logic [5:0] kw_lookup(kwbuf_t b, logic [3:0] len);
    logic [55:0] w;
    logic [5:0] t;
    w = b;
    t = T_IDENT;
    unique case (len)
      4'd2: begin
        if (w[15:0] == {"R", "O"}) t = 6'd12;
        else if (w[15:0] == {"Y", "B"}) t = 6'd17;
      end
      4'd3: begin
        unique case (w[23:0])
          {"D", "N", "A"}: t = 6'd11;
          {"T", "O", "N"}: t = 6'd13;
          {"C", "S", "A"}: t = 6'd18;
          {"T", "E", "S"}: t = 6'd22;
          {"T", "N", "I"}: t = 6'd25;
          {"Y", "E", "K"}: t = 6'd29;
          default: t = T_IDENT;
        endcase
      end
      4'd4: begin
        unique case (w[31:0])
          {"M", "O", "R", "F"}: t = 6'd9;
          {"C", "S", "E", "D"}: t = 6'd19;
          {"O", "T", "N", "I"}: t = 6'd21;
          {"L", "L", "U", "N"}: t = 6'd30;
          {"E", "U", "R", "T"}: t = 6'd31;
          default: t = T_IDENT;
        endcase
      end
      4'd5: begin
        unique case (w[39:0])
          {"E", "R", "E", "H", "W"}: t = 6'd10;
          {"T", "I", "M", "I", "L"}: t = 6'd14;
          {"R", "E", "D", "R", "O"}: t = 6'd16;
          {"E", "L", "B", "A", "T"}: t = 6'd24;
          {"E", "S", "L", "A", "F"}: t = 6'd31;
          default: t = T_IDENT;
        endcase
      end
      4'd6: begin
        unique case (w[47:0])
          {"T", "C", "E", "L", "E", "S"}: t = 6'd5;
          {"T", "R", "E", "S", "N", "I"}: t = 6'd6;
          {"E", "T", "A", "D", "P", "U"}: t = 6'd7;
          {"E", "T", "E", "L", "E", "D"}: t = 6'd8;
          {"T", "E", "S", "F", "F", "O"}: t = 6'd15;
          {"S", "E", "U", "L", "A", "V"}: t = 6'd20;
          {"E", "T", "A", "E", "R", "C"}: t = 6'd23;
          default: t = T_IDENT;
        endcase
      end
      4'd7: begin
        unique case (w)
          {"N", "A", "E", "L", "O", "O", "B"}: t = 6'd26;
          {"R", "A", "H", "C", "R", "A", "V"}: t = 6'd27;
          {"Y", "R", "A", "M", "I", "R", "P"}: t = 6'd28;
          default: t = T_IDENT;
        endcase
      end
      default: t = T_IDENT;
    endcase
    return t;
  endfunction

  function automatic logic [7:0] to_upper(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

endpackage

FILE: sv/sts_core.sv
// Scanner core: mode, position and keyword state, and per-byte token decisions.
`timescale 1ns / 1ps
module sts_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            kind,
  input  logic [7:0]      byte_req,
  output sts_pkg::token_t tok0,
  output sts_pkg::token_t tok1,
  output logic [1:0]      count
);
  import sts_pkg::*;

  mode_t mode, mode_next;
  logic [PosBits-1:0] pos, tstart, tstart_next;
  logic [23:0] line, tline, tline_next, line_next;
  logic [15:0] col, tcol, tcol_next, col_next;
  kwbuf_t kwbuf, kwbuf_next;
  logic too_long, too_long_next;

  logic [PosBits-1:0] nxt, wlen;
  logic is_let, is_dig, is_wrd, is_blank;
  logic [5:0] wtype;

  assign nxt = pos + 1'b1;
  assign wlen = pos - tstart;
  assign is_let = (byte_req >= "A" && byte_req <= "Z") || (byte_req >= "a" && byte_req <= "z");
  assign is_dig = byte_req >= "0" && byte_req <= "9";
  assign is_wrd = is_let || is_dig || byte_req == "_";
  assign is_blank = byte_req == " " || byte_req == 8'h09 || byte_req == 8'h0D || byte_req == 8'h0A;
  assign wtype = (too_long || wlen > PosBits'(KwMaxLen)) ? T_IDENT
                 : kw_lookup(kwbuf, wlen[3:0]);

  always_comb begin
    token_t t_pend, t_open, t_eof;
    logic have_pend, open_emits, open_start, do_open;
    logic [5:0] single;
    mode_t open_mode;

    mode_next = mode;
    tstart_next = tstart;
    tline_next = tline;
    tcol_next = tcol;
    kwbuf_next = kwbuf;
    too_long_next = too_long;
    have_pend = 1'b0;
    do_open = 1'b0;

    // pending token of the current mode, ending at pos
    t_pend.token_type = T_IDENT;
    t_pend.error_code = E_NONE;
    t_pend.start_offset = 32'(tstart);
    t_pend.span_length = 32'(pos - tstart);
    t_pend.first_line = tline;
    t_pend.start_column = tcol;

    // token opened by this byte (single-char ones only)
    open_mode = M_IDLE;
    open_emits = 1'b0;
    single = T_INVALID;
    unique case (byte_req)
      "-": open_mode = M_DASH;
      "/": open_mode = M_SLASH;
      "<": open_mode = M_LT;
      ">": open_mode = M_GT;
      "!": open_mode = M_BANG;
      "'": open_mode = M_QUOTED;
      "(": begin open_emits = 1'b1; single = T_LPAREN; end
      ")": begin open_emits = 1'b1; single = T_RPAREN; end
      ",": begin open_emits = 1'b1; single = T_COMMA; end
      ";": begin open_emits = 1'b1; single = T_SEMI; end
      ".": begin open_emits = 1'b1; single = T_DOT; end
      "+": begin open_emits = 1'b1; single = T_PLUS; end
      "*": begin open_emits = 1'b1; single = T_STAR; end
      "%": begin open_emits = 1'b1; single = T_PERCENT; end
      "=": begin open_emits = 1'b1; single = T_EQ; end
      default: begin
        if (is_let || byte_req == "_") open_mode = M_WORD;
        else if (is_dig) open_mode = M_DIGITS;
        else if (!is_blank) open_emits = 1'b1;
      end
    endcase
    open_start = !is_blank;
    t_open.token_type = single;
    t_open.error_code = (single == T_INVALID) ? E_CHAR : E_NONE;
    t_open.start_offset = 32'(pos);
    t_open.span_length = 32'd1;
    t_open.first_line = line;
    t_open.start_column = col;

    t_eof.token_type = T_EOF;
    t_eof.error_code = E_NONE;
    t_eof.start_offset = 32'(pos);
    t_eof.span_length = 32'd0;
    t_eof.first_line = line;
    t_eof.start_column = col;

    if (kind) begin
      have_pend = 1'b1;
      unique case (mode)
        M_WORD: t_pend.token_type = wtype;
        M_DIGITS: t_pend.token_type = T_INTEGER;
        M_DASH: t_pend.token_type = T_MINUS;
        M_SLASH: t_pend.token_type = T_SLASH;
        M_LT: t_pend.token_type = T_LT;
        M_GT: t_pend.token_type = T_GT;
        M_BANG: begin t_pend.token_type = T_INVALID; t_pend.error_code = E_BANG; end
        M_QUOTED: begin t_pend.token_type = T_INVALID; t_pend.error_code = E_UNTERM; end
        M_QUOTE_SEEN: t_pend.token_type = T_STRING;
        default: have_pend = 1'b0;
      endcase
    end else begin
      unique case (mode)
        M_WORD: begin
          if (is_wrd) begin
            if (!too_long && wlen < PosBits'(KwMaxLen))
              kwbuf_next[wlen[KwIdxBits-1:0]] = to_upper(byte_req);
            else too_long_next = 1'b1;
          end else begin
            have_pend = 1'b1; t_pend.token_type = wtype; do_open = 1'b1;
          end
        end
        M_DIGITS: if (!is_dig) begin
          have_pend = 1'b1; t_pend.token_type = T_INTEGER; do_open = 1'b1;
        end
        M_DASH: begin
          if (byte_req == "-") mode_next = M_LINE_REM;
          else begin have_pend = 1'b1; t_pend.token_type = T_MINUS; do_open = 1'b1; end
        end
        M_SLASH: begin
          if (byte_req == "*") mode_next = M_BLOCK_REM;
          else begin have_pend = 1'b1; t_pend.token_type = T_SLASH; do_open = 1'b1; end
        end
        M_LT, M_GT, M_BANG: begin
          have_pend = 1'b1;
          if (byte_req == "=") begin
            t_pend.token_type = (mode == M_LT) ? T_LE : (mode == M_GT) ? T_GE : T_NE;
            t_pend.span_length = 32'(nxt - tstart);
            mode_next = M_IDLE;
          end else begin
            if (mode == M_BANG) begin
              t_pend.token_type = T_INVALID; t_pend.error_code = E_BANG;
            end else t_pend.token_type = (mode == M_LT) ? T_LT : T_GT;
            do_open = 1'b1;
          end
        end
        M_QUOTED: if (byte_req == "'") mode_next = M_QUOTE_SEEN;
        M_QUOTE_SEEN: begin
          if (byte_req == "'") mode_next = M_QUOTED;
          else begin have_pend = 1'b1; t_pend.token_type = T_STRING; do_open = 1'b1; end
        end
        M_LINE_REM: if (byte_req == 8'h0A) mode_next = M_IDLE;
        M_BLOCK_REM: if (byte_req == "*") mode_next = M_BLOCK_STAR;
        M_BLOCK_STAR: begin
          if (byte_req == "/") mode_next = M_IDLE;
          else if (byte_req != "*") mode_next = M_BLOCK_REM;
        end
        default: do_open = 1'b1;
      endcase
      if (do_open) begin
        mode_next = open_mode;
        if (open_start) begin
          tstart_next = pos; tline_next = line; tcol_next = col;
        end
        if (open_mode == M_WORD) begin
          kwbuf_next[0] = to_upper(byte_req);
          too_long_next = 1'b0;
        end
      end
    end

    // pack results: pending first, then opened single or eof
    tok0 = t_pend;
    tok1 = kind ? t_eof : t_open;
    count = 2'd0;
    if (kind) begin
      if (have_pend) count = 2'd2;
      else begin tok0 = t_eof; count = 2'd1; end
    end else begin
      if (have_pend && do_open && open_emits) count = 2'd2;
      else if (have_pend) count = 2'd1;
      else if (do_open && open_emits) begin tok0 = t_open; count = 2'd1; end
    end
  end

  always_comb begin
    line_next = line;
    col_next = col;
    if (byte_req == 8'h0A) begin
      if (line < LineSat) line_next = line + 24'd1;
      col_next = 16'd1;
    end else if (col < ColSat) col_next = col + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && kind)) begin
      mode <= M_IDLE;
      pos <= '0;
      line <= 24'd1;
      col <= 16'd1;
      tstart <= '0;
      tline <= 24'd1;
      tcol <= 16'd1;
      too_long <= 1'b0;
    end else if (step) begin
      mode <= mode_next;
      pos <= nxt;
      line <= line_next;
      col <= col_next;
      tstart <= tstart_next;
      tline <= tline_next;
      tcol <= tcol_next;
      too_long <= too_long_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) kwbuf <= kwbuf_next;
  end
endmodule

FILE: sv/sts_outq.sv
// Output queue: holds up to two tokens per word and drains them one at a time.
`timescale 1ns / 1ps
module sts_outq (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  sts_pkg::token_t tok0,
  input  sts_pkg::token_t tok1,
  input  logic [1:0]      count,
  output logic            can_load,
  output logic            out_valid,
  input  logic            out_ready,
  output sts_pkg::token_t head,
  output logic            head_last
);
  import sts_pkg::*;

  token_t slot0, slot1;
  logic [1:0] fill;
  logic take;

  assign take = out_valid && out_ready;
  assign out_valid = fill != 2'd0;
  assign head = slot0;
  assign head_last = fill == 2'd1;
  // accept a new word when empty or the last held token leaves this cycle
  assign can_load = (fill == 2'd0) || (fill == 2'd1 && out_ready);

  always_ff @(posedge clk) begin
    if (rst) fill <= 2'd0;
    else if (load && can_load) fill <= count;
    else if (take) fill <= fill - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      slot0 <= tok0;
      slot1 <= tok1;
    end else if (take) slot0 <= slot1;
  end
endmodule

FILE: sv/sql_token_scanner_unit.sv
// Top level: streaming SQL token scanner with a two-token result queue.
`timescale 1ns / 1ps
// Usage:
//   Input channel (valid/ready): each word is kind plus byte_req. kind 0
//   carries one source byte, kind 1 marks end of source.
//   Output channel (valid/ready): one token per word with type, error code,
//   start offset, raw span length, first line and column; last marks the
//   final token caused by one input word.
//   Each input word yields zero, one or two tokens; an end word always yields
//   the Eof token, preceded by any pending token, and returns the scanner to
//   its reset state.
//   Latency: a token is shown the cycle after the word that ends it.
//   Throughput: one byte per cycle while each byte yields at most one token
//   and the receiver keeps up; the rate is set by the result queue, which
//   drains one token per cycle and takes no word while it holds two.
//   A new word is taken in the same cycle the last queued token leaves.
//   Reset (rst, synchronous) clears the mode, position, line and column
//   counters and empties the queue.
//   When the receiver stalls the queued tokens hold and ready drops until
//   the last of them is taken; no state advances meanwhile.
module sql_token_scanner_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  byte_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [5:0]  token_type,
  output logic [1:0]  error_code,
  output logic [31:0] start_offset,
  output logic [31:0] span_length,
  output logic [23:0] first_line,
  output logic [15:0] start_column,
  output logic        last
);
  import sts_pkg::*;

  token_t tok0, tok1, head;
  logic [1:0] count;
  logic can_load, step;

  // advance the scanner only on an accepted word
  assign in_ready = can_load;
  assign step = in_valid && in_ready;

  sts_core u_core (
    .clk(clk), .rst(rst), .step(step), .kind(kind), .byte_req(byte_req),
    .tok0(tok0), .tok1(tok1), .count(count)
  );

  sts_outq u_outq (
    .clk(clk), .rst(rst), .load(step), .tok0(tok0), .tok1(tok1), .count(count),
    .can_load(can_load), .out_valid(out_valid), .out_ready(out_ready),
    .head(head), .head_last(last)
  );

  assign token_type = head.token_type;
  assign error_code = head.error_code;
  assign start_offset = head.start_offset;
  assign span_length = head.span_length;
  assign first_line = head.first_line;
  assign start_column = head.start_column;

  // an end word always leaves an Eof token as the last one queued
  a_end_gives_output: assert property (@(posedge clk) disable iff (rst)
    (step && kind) |=> out_valid)
    else $error("end word produced no token");

  // error codes appear only on invalid tokens
  a_err_only_invalid: assert property (@(posedge clk) disable iff (rst)
    (out_valid && error_code != E_NONE) |-> token_type == T_INVALID)
    else $error("error code on a valid token");

  // input is never taken while more than one token waits
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last) |-> !in_ready)
    else $error("input accepted over a full queue");
endmodule

FILE: dv/sql_token_checker.sv
// Checker: watches both channels of the token scanner, predicts tokens and compares them.
`timescale 1ns / 1ps
module sql_token_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        kind,
  input  logic [7:0]  byte_req,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [5:0]  token_type,
  input  logic [1:0]  error_code,
  input  logic [31:0] start_offset,
  input  logic [31:0] span_length,
  input  logic [23:0] first_line,
  input  logic [15:0] start_column,
  input  logic        last,
  output int          fail_count,
  output int          pending_tokens
);
  import sts_pkg::*;

  typedef struct {
    logic [5:0]  ttype;
    logic [1:0]  err;
    logic [31:0] offs;
    logic [31:0] span;
    logic [23:0] line;
    logic [15:0] col;
    logic        fin;
  } tok_s;

  tok_s token_queue[$];

  mode_t       mode;
  logic [31:0] pos, tstart;
  logic [23:0] line_cnt, tline;
  logic [15:0] col_cnt, tcol;
  kwbuf_t      kbuf;
  logic        too_long;
  tok_s        step_toks[$];

  assign pending_tokens = token_queue.size();

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic logic is_num(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic [7:0] upcase(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  // Keyword match written out as a string table.
  function automatic logic [5:0] classify_word();
    string kw[28];
    logic [5:0] code[28];
    logic [31:0] n;
    string w;
    n = pos - tstart;
    kw = '{"SELECT", "INSERT", "UPDATE", "DELETE", "FROM", "WHERE", "AND", "OR", "NOT",
           "LIMIT", "OFFSET", "ORDER", "BY", "ASC", "DESC", "VALUES", "INTO", "SET",
           "CREATE", "TABLE", "INT", "BOOLEAN", "VARCHAR", "PRIMARY", "KEY", "NULL",
           "TRUE", "FALSE"};
    code = '{5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20, 21, 22, 23, 24,
             25, 26, 27, 28, 29, 30, 31, 31};
    if (too_long || n > KwMaxLen) return T_IDENT;
    w = "";
    for (int i = 0; i < n; i++) w = {w, string'(kbuf[i])};
    for (int i = 0; i < 28; i++) if (kw[i] == w) return code[i];
    return T_IDENT;
  endfunction

  task automatic emit(logic [5:0] t, logic [1:0] e, logic [31:0] endp);
    tok_s r;
    r.ttype = t; r.err = e; r.offs = tstart; r.span = endp - tstart;
    r.line = tline; r.col = tcol; r.fin = 1'b0;
    step_toks = {step_toks, r};
  endtask

  task automatic mark();
    tstart = pos; tline = line_cnt; tcol = col_cnt;
  endtask

  task automatic clear_state();
    mode = M_IDLE; pos = '0; line_cnt = 1; col_cnt = 1;
    tstart = '0; tline = 1; tcol = 1; kbuf = '0; too_long = 1'b0;
  endtask

  task automatic begin_token(logic [7:0] c);
    mode = M_IDLE;
    if (c == " " || c == 8'h09 || c == 8'h0d || c == 8'h0a) return;
    mark();
    if (is_alpha(c) || c == "_") begin
      kbuf[0] = upcase(c); too_long = 1'b0; mode = M_WORD;
    end else if (is_num(c)) mode = M_DIGITS;
    else begin
      case (c)
        "-": mode = M_DASH;
        "/": mode = M_SLASH;
        "<": mode = M_LT;
        ">": mode = M_GT;
        "!": mode = M_BANG;
        "'": mode = M_QUOTED;
        "(": emit(T_LPAREN, E_NONE, pos + 1);
        ")": emit(T_RPAREN, E_NONE, pos + 1);
        ",": emit(T_COMMA, E_NONE, pos + 1);
        ";": emit(T_SEMI, E_NONE, pos + 1);
        ".": emit(T_DOT, E_NONE, pos + 1);
        "+": emit(T_PLUS, E_NONE, pos + 1);
        "*": emit(T_STAR, E_NONE, pos + 1);
        "%": emit(T_PERCENT, E_NONE, pos + 1);
        "=": emit(T_EQ, E_NONE, pos + 1);
        default: emit(T_INVALID, E_CHAR, pos + 1);
      endcase
    end
  endtask

  task automatic predict_tokens(logic k, logic [7:0] c);
    logic [31:0] idx;
    step_toks.delete();
    if (k) begin
      case (mode)
        M_WORD: emit(classify_word(), E_NONE, pos);
        M_DIGITS: emit(T_INTEGER, E_NONE, pos);
        M_DASH: emit(T_MINUS, E_NONE, pos);
        M_SLASH: emit(T_SLASH, E_NONE, pos);
        M_LT: emit(T_LT, E_NONE, pos);
        M_GT: emit(T_GT, E_NONE, pos);
        M_BANG: emit(T_INVALID, E_BANG, pos);
        M_QUOTED: emit(T_INVALID, E_UNTERM, pos);
        M_QUOTE_SEEN: emit(T_STRING, E_NONE, pos);
        default: ;
      endcase
      mark();
      emit(T_EOF, E_NONE, pos);
      clear_state();
    end else begin
      case (mode)
        M_WORD:
          if (is_alpha(c) || is_num(c) || c == "_") begin
            idx = pos - tstart;
            if (!too_long && idx < KwMaxLen) kbuf[idx] = upcase(c);
            else too_long = 1'b1;
          end else begin
            emit(classify_word(), E_NONE, pos); begin_token(c);
          end
        M_DIGITS:
          if (!is_num(c)) begin
            emit(T_INTEGER, E_NONE, pos); begin_token(c);
          end
        M_DASH:
          if (c == "-") mode = M_LINE_REM;
          else begin
            emit(T_MINUS, E_NONE, pos); begin_token(c);
          end
        M_SLASH:
          if (c == "*") mode = M_BLOCK_REM;
          else begin
            emit(T_SLASH, E_NONE, pos); begin_token(c);
          end
        M_LT, M_GT, M_BANG:
          if (c == "=") begin
            emit(mode == M_LT ? T_LE : mode == M_GT ? T_GE : T_NE, E_NONE, pos + 1);
            mode = M_IDLE;
          end else begin
            if (mode == M_BANG) emit(T_INVALID, E_BANG, pos);
            else emit(mode == M_LT ? T_LT : T_GT, E_NONE, pos);
            begin_token(c);
          end
        M_QUOTED: if (c == "'") mode = M_QUOTE_SEEN;
        M_QUOTE_SEEN:
          if (c == "'") mode = M_QUOTED;
          else begin
            emit(T_STRING, E_NONE, pos); begin_token(c);
          end
        M_LINE_REM: if (c == 8'h0a) mode = M_IDLE;
        M_BLOCK_REM: if (c == "*") mode = M_BLOCK_STAR;
        M_BLOCK_STAR:
          if (c == "/") mode = M_IDLE;
          else if (c != "*") mode = M_BLOCK_REM;
        default: begin_token(c);
      endcase
      pos = pos + 1;
      if (c == 8'h0a) begin
        if (line_cnt < LineSat) line_cnt++;
        col_cnt = 1;
      end else if (col_cnt < ColSat) col_cnt++;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].fin = 1'b1;
    token_queue = {token_queue, step_toks};
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  always @(posedge clk) begin
    tok_s w;
    if (rst) begin
      clear_state();
      token_queue.delete();
      fail_count = 0;
    end else begin
      // Check output before predicting: a token never shows in its own input cycle.
      if (out_valid && out_ready) begin
        if (token_queue.size() == 0) begin
          report_mismatch("unexpected token, type", token_type, '0);
        end else begin
          w = token_queue.pop_front();
          if (token_type !== w.ttype) report_mismatch("token_type", token_type, w.ttype);
          if (error_code !== w.err) report_mismatch("error_code", error_code, w.err);
          if (start_offset !== w.offs) report_mismatch("start_offset", start_offset, w.offs);
          if (span_length !== w.span) report_mismatch("span_length", span_length, w.span);
          if (first_line !== w.line) report_mismatch("first_line", first_line, w.line);
          if (start_column !== w.col) report_mismatch("start_column", start_column, w.col);
          if (last !== w.fin) report_mismatch("last", last, w.fin);
        end
      end
      if (in_valid && in_ready) predict_tokens(kind, byte_req);
    end
  end

endmodule

FILE: dv/tb_sql_token_scanner_unit.sv
// Testbench top: drives SQL text into the token scanner and gives the verdict.
`timescale 1ns / 1ps
module tb_sql_token_scanner_unit;
  import sts_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        kind = 1'b0;
  logic [7:0]  byte_req = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [5:0]  token_type;
  logic [1:0]  error_code;
  logic [31:0] start_offset, span_length;
  logic [23:0] first_line;
  logic [15:0] start_column;
  logic        last;
  int          fail_count, pending_tokens;
  int          cycle_count = 0;
  logic        hold_off = 1'b0;

  localparam int CycleLimit = 400000;

  always #6 clk = ~clk;

  sql_token_scanner_unit DUT (.*);

  sql_token_checker u_checker (.*);

  // Stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls per word, plus one long hold-off window.
  initial begin
    int gap;
    repeat (5) @(posedge clk);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        @(posedge clk);
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_ready <= 1'b1;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  // Hold the receiver off for a long stretch partway through the run.
  initial begin
    repeat (3000) @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  logic [7:0] text_q[$];
  logic       kind_q[$];
  int         burst_mode = 0;

  // Send one word: optional idle gap, then hold valid until accepted.
  task automatic send_word(logic k, logic [7:0] b);
    int gap;
    gap = (burst_mode > 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    byte_req <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_word(1'b0, s[i]);
  endtask

  // Pick one fragment of SQL-ish text, mostly well-formed.
  function automatic string pick_fragment();
    string kws[28];
    string f;
    int r;
    kws = '{"select", "INSERT", "Update", "delete", "from", "WHERE", "and", "Or", "not",
            "limit", "OFFSET", "order", "BY", "asc", "desc", "values", "into", "set",
            "Create", "table", "int", "boolean", "VARCHAR", "primary", "key", "null",
            "True", "false"};
    r = $urandom_range(0, 19);
    case (r)
      0, 1, 2: f = kws[$urandom_range(0, 27)];
      3: f = {"_id", $sformatf("%0d", $urandom_range(0, 999))};
      4: f = "selects_longname";
      5: f = $sformatf("%0d", $urandom);
      6: f = "'it''s'";
      7: f = "'abc'";
      8: f = "-- note\n";
      9: f = "/* blk ** */";
      10: f = "<=";
      11: f = ">=";
      12: f = "!=";
      13: f = "!x";
      14: f = "( ) , ; . + * % =";
      15: f = "\n";
      16: f = "\t\r ";
      17: f = "< > - /";
      default: f = " ";
    endcase
    return f;
  endfunction

  initial begin
    string f;
    int    items;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed part: operators, keywords, strings, comments, invalid and high bytes.
    send_text("SELECT a,b FROM t WHERE x<=1;");
    send_word(1'b1, 8'h00);
    send_text("'it''s' != ! >= <> --c\n/**/");
    send_word(1'b0, 8'h80);
    send_word(1'b0, 8'hFF);
    send_word(1'b0, "@");
    send_word(1'b1, 8'h7F);
    send_text("'open");
    send_word(1'b1, 8'h00);
    send_text("/* open");
    send_word(1'b1, 8'h00);
    send_text("x<");
    send_word(1'b1, 8'h00);
    send_text("!");
    send_word(1'b1, 8'h00);
    send_text("-");
    send_word(1'b1, 8'h00);
    send_text("BOOLEANS FaLsE 42");
    send_word(1'b1, 8'h00);

    // Random part: fragments with occasional raw noise and end words.
    items = 0;
    while (items < 1250) begin
      burst_mode = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : burst_mode;
      if ($urandom_range(0, 9) == 0) begin
        send_word($urandom_range(0, 15) == 0, 8'($urandom_range(0, 255)));
        items++;
      end else begin
        f = pick_fragment();
        send_text(f);
        items += f.len();
      end
      if ($urandom_range(0, 39) == 0) begin
        send_word(1'b1, 8'($urandom_range(0, 255)));
        items++;
      end
      if (burst_mode > 0) burst_mode--;
    end
    send_word(1'b1, 8'h00);
    in_valid <= 1'b0;

    while (pending_tokens != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
